// ===== src/ichc_pkg.sv =====
// Shared types, constants and helper functions for the iteration-count HSV colouriser.
// The top level and its hue and channel stages use it; it depends on nothing else.
`default_nettype none

package ichc_pkg;

  // Default width of the iteration count input
  localparam int unsigned DEFAULT_COUNT_WIDTH = 16;

  // Hue repeats every HUE_PERIOD counts; a sector is FRAC_DEN fiftieths wide
  localparam int unsigned HUE_PERIOD = 100;
  localparam int unsigned FRAC_DEN   = 50;
  localparam int unsigned UNIT       = 256;
  localparam int unsigned FULL_SCALE = UNIT * FRAC_DEN;

  // Byte-weighted count sum, quotient by 100, residue
  localparam int unsigned SUM_W     = 17;
  localparam int unsigned Q_W       = 11;
  localparam int unsigned K_W       = 7;
  localparam int unsigned MOD_RECIP = 5243;
  localparam int unsigned MOD_SHIFT = 19;

  // Colour arithmetic widths
  localparam int unsigned SAT_W  = 9;
  localparam int unsigned VS_W   = 17;
  localparam int unsigned NUM_W  = 22;
  localparam int unsigned RAMP_W = 6;
  localparam int unsigned SEC_W  = 3;

  // Numerator to byte: floor(num * 51 / 2^17) then divide by five
  localparam int unsigned BYTE_MUL    = 51;
  localparam int unsigned BYTE_SHIFT  = 17;
  localparam int unsigned Y_W         = 11;
  localparam int unsigned DIV5_RECIP  = 52429;
  localparam int unsigned DIV5_SHIFT  = 18;

  localparam int unsigned PIXEL_W = 24;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SATURATION  = 2'd0,
    CFG_BRIGHTNESS  = 2'd1,
    CFG_SWAP_ORDER  = 2'd2,
    CFG_BLACK_COLOR = 2'd3
  } cfg_reg_e;

  // Weight of count byte idx modulo the hue period, i.e. (256^idx) mod 100
  function automatic int unsigned byte_weight(input int unsigned idx);
    int unsigned w;
    w = 1;
    for (int unsigned j = 0; j < idx; j++) begin
      w = (w * UNIT) % HUE_PERIOD;
    end
    return w;
  endfunction

  // Saturate a 1/256 fraction register to 1.0
  function automatic logic [SAT_W-1:0] clamp_unit(input logic [SAT_W-1:0] v);
    logic [SAT_W-1:0] r;
    r = (v > SAT_W'(UNIT)) ? SAT_W'(UNIT) : v;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/iteration_count_hsv_colorizer.sv =====
// Iteration-count HSV colouriser, top level: pipeline control, configuration and packing.
// Depends on ichc_pkg, ichc_hue and ichc_chan.
//
// Takes one escape-iteration count per clock while the output is not stalled and
// returns one packed 24-bit pixel per transaction. The seven-stage pipeline has
// three hue stages (byte fold, reciprocal quotient by 100, residue and sector), the
// ramp multiply, the channel select, and two channel-to-byte stages. Every stage
// carries its own valid bit and loads whenever the stage after it moves or holds a
// bubble, so stalls close gaps without losing data. Bounded points return the black
// colour register unswapped. Configuration writes are always accepted and must only
// be made while the pipeline is empty.
`default_nettype none

module iteration_count_hsv_colorizer
  import ichc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Input stream
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // tdata: iter_count [COUNT_WIDTH-1:0], zero padded to whole bytes
  input  wire logic [((COUNT_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // tuser: diverged [0]
  input  wire logic                                  s_axis_tuser,
  // Output stream
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // tdata: pixel [23:0]
  output logic      [PIXEL_W-1:0]                    m_axis_tdata,
  // Configuration writes
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [1:0]                            cfg_index_i,
  input  wire logic [PIXEL_W-1:0]                    cfg_data_i
);

  localparam int unsigned Stages = 7;
  localparam int unsigned XW     = VS_W + RAMP_W;

  // Configuration registers and values derived from them
  logic [SAT_W-1:0]   sat_q, bri_q;
  logic               swap_q;
  logic [PIXEL_W-1:0] black_q;
  logic [SAT_W-1:0]   sat_c, bri_c;
  logic [VS_W-1:0]    vs_q;
  logic [NUM_W-1:0]   vm_q, m_q;

  // Pipeline control
  logic [Stages-1:0] vld_q, vld_d, ld;
  logic [Stages-1:0] div_q;

  // Datapath
  logic [SEC_W-1:0]  hue_sector;
  logic [RAMP_W-1:0] hue_ramp;
  logic [SEC_W-1:0]  sec4_q;
  logic [NUM_W-1:0]  x_q;
  logic [XW-1:0]     x_prod;
  logic [NUM_W-1:0]  xm;
  logic [NUM_W-1:0]  r_num_q, g_num_q, b_num_q;
  logic [NUM_W-1:0]  r_num_d, g_num_d, b_num_d;
  logic [7:0]        r_byte, g_byte, b_byte;
  logic [PIXEL_W-1:0] coloured;

  // Take configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q   <= SAT_W'(UNIT);
      bri_q   <= SAT_W'(UNIT);
      swap_q  <= 1'b0;
      black_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SATURATION:  sat_q   <= cfg_data_i[SAT_W-1:0];
        CFG_BRIGHTNESS:  bri_q   <= cfg_data_i[SAT_W-1:0];
        CFG_SWAP_ORDER:  swap_q  <= cfg_data_i[0];
        CFG_BLACK_COLOR: black_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Precompute v*s, v*256*50 and m from the registers
  assign sat_c = clamp_unit(sat_q);
  assign bri_c = clamp_unit(bri_q);

  always_ff @(posedge clk_i) begin
    vs_q <= VS_W'(sat_c) * VS_W'(bri_c);
    vm_q <= NUM_W'(bri_c) * NUM_W'(FULL_SCALE);
    m_q  <= vm_q - NUM_W'(vs_q) * NUM_W'(FRAC_DEN);
  end

  // Advance each stage when the next one moves or is empty
  always_comb begin
    ld[Stages-1] = !vld_q[Stages-1] || m_axis_tready;
    for (int i = Stages - 2; i >= 0; i--) begin
      ld[i] = !vld_q[i] || ld[i+1];
    end
  end

  always_comb begin
    vld_d[0] = s_axis_tvalid;
    for (int i = 1; i < Stages; i++) begin
      vld_d[i] = vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < Stages; i++) begin
        if (ld[i]) begin
          vld_q[i] <= vld_d[i];
        end
      end
    end
  end

  assign s_axis_tready = ld[0];
  assign m_axis_tvalid = vld_q[Stages-1];

  // Carry the diverged flag alongside the data
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      div_q[0] <= s_axis_tuser;
    end
    for (int i = 1; i < Stages; i++) begin
      if (ld[i]) begin
        div_q[i] <= div_q[i-1];
      end
    end
  end

  // Stages 1 to 3: hue sector and ramp
  ichc_hue #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_hue (
    .clk_i   (clk_i),
    .en_i    (ld[2:0]),
    .count_i (s_axis_tdata[COUNT_WIDTH-1:0]),
    .sector_o(hue_sector),
    .ramp_o  (hue_ramp)
  );

  // Stage 4: x = v*s*ramp
  assign x_prod = XW'(vs_q) * XW'(hue_ramp);

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      x_q    <= NUM_W'(x_prod);
      sec4_q <= hue_sector;
    end
  end

  // Stage 5: add m and route to the channels by sector
  assign xm = x_q + m_q;

  always_comb begin
    unique case (sec4_q)
      SEC_W'(0): begin r_num_d = vm_q; g_num_d = xm;   b_num_d = m_q;  end
      SEC_W'(1): begin r_num_d = xm;   g_num_d = vm_q; b_num_d = m_q;  end
      SEC_W'(2): begin r_num_d = m_q;  g_num_d = vm_q; b_num_d = xm;   end
      SEC_W'(3): begin r_num_d = m_q;  g_num_d = xm;   b_num_d = vm_q; end
      SEC_W'(4): begin r_num_d = xm;   g_num_d = m_q;  b_num_d = vm_q; end
      default:   begin r_num_d = vm_q; g_num_d = m_q;  b_num_d = xm;   end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      r_num_q <= r_num_d;
      g_num_q <= g_num_d;
      b_num_q <= b_num_d;
    end
  end

  // Stages 6 and 7: numerators to bytes
  ichc_chan u_chan_r (
    .clk_i (clk_i),
    .en_i  (ld[6:5]),
    .num_i (r_num_q),
    .byte_o(r_byte)
  );

  ichc_chan u_chan_g (
    .clk_i (clk_i),
    .en_i  (ld[6:5]),
    .num_i (g_num_q),
    .byte_o(g_byte)
  );

  ichc_chan u_chan_b (
    .clk_i (clk_i),
    .en_i  (ld[6:5]),
    .num_i (b_num_q),
    .byte_o(b_byte)
  );

  // Pack the pixel, or hand out the black colour for bounded points
  assign coloured     = swap_q ? {b_byte, g_byte, r_byte} : {r_byte, g_byte, b_byte};
  assign m_axis_tdata = div_q[Stages-1] ? coloured : black_q;

  // An empty first stage always takes a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> s_axis_tready)
    else $error("input stalled with an empty first stage");

  // A draining output keeps the whole pipeline moving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[Stages-1] && m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while the output drains");

  // Hue stage yields a legal sector and ramp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (hue_sector <= SEC_W'(5) && hue_ramp <= RAMP_W'(FRAC_DEN)))
    else $error("hue sector or ramp out of range");

  // Channel numerators never exceed v*256*50
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> (r_num_q <= vm_q && g_num_q <= vm_q && b_num_q <= vm_q))
    else $error("channel numerator above full scale");

endmodule

`default_nettype wire

// ===== src/ichc_hue.sv =====
// Three-stage hue front end: iteration count to HSV sector and ramp fraction.
// Depends on ichc_pkg; load enables come from the pipeline control in the top level.
`default_nettype none

module ichc_hue
  import ichc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic [2:0]             en_i,
  input  wire logic [COUNT_WIDTH-1:0] count_i,
  output logic      [SEC_W-1:0]       sector_o,
  output logic      [RAMP_W-1:0]      ramp_o
);

  localparam int unsigned NumBytes = (COUNT_WIDTH + 7) / 8;
  localparam int unsigned PadW     = NumBytes * 8;
  localparam int unsigned ProdW    = SUM_W + 13;

  logic [PadW-1:0]   cnt_pad;
  logic [SUM_W-1:0]  sum_d, sum_q;
  logic [SUM_W-1:0]  sum2_q;
  logic [ProdW-1:0]  prod;
  logic [Q_W-1:0]    q_d, q_q;
  logic [SUM_W-1:0]  rem, rem_fix;
  logic [K_W-1:0]    k;
  logic [8:0]        sixths, base, frac;
  logic [SEC_W-1:0]  sector_d, sector_q;
  logic [RAMP_W-1:0] ramp_d, ramp_q;

  // Stage 1: fold the count bytes with their weights modulo 100
  assign cnt_pad = PadW'(count_i);

  always_comb begin
    sum_d = '0;
    for (int unsigned i = 0; i < NumBytes; i++) begin
      sum_d = sum_d + SUM_W'(cnt_pad[8*i +: 8]) * SUM_W'(byte_weight(i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sum_q <= sum_d;
    end
  end

  // Stage 2: quotient by 100 through the reciprocal
  assign prod = ProdW'(sum_q) * ProdW'(MOD_RECIP);
  assign q_d  = Q_W'(prod >> MOD_SHIFT);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sum2_q <= sum_q;
      q_q    <= q_d;
    end
  end

  // Stage 3: residue, sector and ramp
  assign rem     = sum2_q - SUM_W'(q_q) * SUM_W'(HUE_PERIOD);
  assign rem_fix = (rem >= SUM_W'(HUE_PERIOD)) ? rem - SUM_W'(HUE_PERIOD) : rem;
  assign k       = K_W'(rem_fix);
  assign sixths  = {2'b00, k} + {1'b0, k, 1'b0};

  always_comb begin
    priority if (k <= K_W'(16)) begin
      sector_d = SEC_W'(0);
    end else if (k <= K_W'(33)) begin
      sector_d = SEC_W'(1);
    end else if (k <= K_W'(49)) begin
      sector_d = SEC_W'(2);
    end else if (k <= K_W'(66)) begin
      sector_d = SEC_W'(3);
    end else if (k <= K_W'(83)) begin
      sector_d = SEC_W'(4);
    end else begin
      sector_d = SEC_W'(5);
    end
  end

  always_comb begin
    base   = 9'(sector_d) * 9'(FRAC_DEN);
    frac   = sixths - base;
    ramp_d = sector_d[0] ? RAMP_W'(FRAC_DEN) - RAMP_W'(frac) : RAMP_W'(frac);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sector_q <= sector_d;
      ramp_q   <= ramp_d;
    end
  end

  assign sector_o = sector_q;
  assign ramp_o   = ramp_q;

endmodule

`default_nettype wire

// ===== src/ichc_chan.sv =====
// Two-stage channel converter: exact floor(255 * num / 3276800) to one byte.
// Depends on ichc_pkg; load enables come from the top level.
`default_nettype none

module ichc_chan
  import ichc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [1:0]        en_i,
  input  wire logic [NUM_W-1:0]  num_i,
  output logic      [7:0]        byte_o
);

  localparam int unsigned P1W = NUM_W + 6;
  localparam int unsigned P2W = Y_W + 16;

  logic [P1W-1:0] p1;
  logic [Y_W-1:0] y_q;
  logic [P2W-1:0] p2;
  logic [8:0]     z;
  logic [7:0]     byte_q;

  // Stage A: scale by 51 and drop 2^17
  assign p1 = P1W'(num_i) * P1W'(BYTE_MUL);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      y_q <= Y_W'(p1 >> BYTE_SHIFT);
    end
  end

  // Stage B: divide by five and saturate to a byte
  assign p2 = P2W'(y_q) * P2W'(DIV5_RECIP);
  assign z  = 9'(p2 >> DIV5_SHIFT);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      byte_q <= (z > 9'd255) ? 8'hFF : z[7:0];
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ===== tb/tb_iteration_count_hsv_colorizer.sv =====
// Self-checking testbench for the iteration-count HSV colouriser: a queued stream driver,
// a stalling result monitor and a pixel predictor built from the colour rules.
// Depends on ichc_pkg and iteration_count_hsv_colorizer.
`timescale 1ns / 1ps

module tb_iteration_count_hsv_colorizer
  import ichc_pkg::*;
();

  localparam int unsigned CNT_W       = DEFAULT_COUNT_WIDTH;
  localparam int unsigned TDATA_W     = ((CNT_W + 7) / 8) * 8;
  localparam int unsigned QUIET_LIMIT = 500;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned RAND_POINTS = 200;

  // Counts on either side of every hue sector boundary and of the period wrap
  localparam int EDGE_COUNTS [12] = '{16, 17, 33, 34, 49, 50, 66, 67, 83, 84, 99, 100};

  typedef struct packed {
    logic             diverged;
    logic [CNT_W-1:0] count;
  } point_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [PIXEL_W-1:0] m_axis_tdata;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i   = CFG_SATURATION;
  logic [PIXEL_W-1:0] cfg_data_i    = '0;

  // Register shadow used by the pixel predictor
  logic [SAT_W-1:0]   sat_reg   = SAT_W'(UNIT);
  logic [SAT_W-1:0]   bri_reg   = SAT_W'(UNIT);
  logic               swap_reg  = 1'b0;
  logic [PIXEL_W-1:0] black_reg = '0;

  point_t             point_q[$];
  logic [PIXEL_W-1:0] pixel_q[$];

  bit  calm = 1'b0;
  int  errors = 0;
  int  points_sent = 0;
  int  bounded_sent = 0;
  int  pixels_seen = 0;
  int  settings_run = 0;

  iteration_count_hsv_colorizer #(
    .COUNT_WIDTH (CNT_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scale a numerator over 65536 * 50 to a byte, truncating
  function automatic longint unsigned scaled_byte(input longint unsigned num);
    longint unsigned b;
    b = (num * 255) / (longint'(UNIT) * UNIT * FRAC_DEN);
    return (b > 255) ? 255 : b;
  endfunction

  // Predict the packed pixel for one point under the current register shadow
  function automatic logic [PIXEL_W-1:0] hsv_pixel(input logic diverged,
                                                   input logic [CNT_W-1:0] count);
    longint unsigned s, v, k, sixths, sector, frac, c, ramp, x, m, r, g, b;
    if (!diverged) return black_reg;
    s      = (sat_reg > UNIT) ? UNIT : sat_reg;
    v      = (bri_reg > UNIT) ? UNIT : bri_reg;
    k      = count % HUE_PERIOD;
    sixths = 3 * k;
    sector = sixths / FRAC_DEN;
    frac   = sixths % FRAC_DEN;
    c      = v * s * FRAC_DEN;
    ramp   = sector[0] ? (FRAC_DEN - frac) : frac;
    x      = v * s * ramp;
    m      = v * UNIT * FRAC_DEN - c;
    case (sector)
      0:       begin r = c; g = x; b = 0; end
      1:       begin r = x; g = c; b = 0; end
      2:       begin r = 0; g = c; b = x; end
      3:       begin r = 0; g = x; b = c; end
      4:       begin r = x; g = 0; b = c; end
      default: begin r = c; g = 0; b = x; end
    endcase
    r = scaled_byte(r + m);
    g = scaled_byte(g + m);
    b = scaled_byte(b + m);
    return swap_reg ? {8'(b), 8'(g), 8'(r)} : {8'(r), 8'(g), 8'(b)};
  endfunction

  // Stream driver: bursts of points separated by random gaps
  int     burst_left = 0;
  int     gap_left   = 0;
  point_t next_pt;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pixel_q.push_back(hsv_pixel(s_axis_tuser, s_axis_tdata[CNT_W-1:0]));
        points_sent++;
        if (!s_axis_tuser) bounded_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0 && !calm) begin
          s_axis_tvalid <= 1'b0;
          gap_left--;
        end else if (point_q.size() != 0) begin
          next_pt = point_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= TDATA_W'(next_pt.count);
          s_axis_tuser  <= next_pt.diverged;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest expected pixel, stall on its own pattern outside calm phases
  logic [PIXEL_W-1:0] want_pixel;
  bit                 ready_state = 1'b1;
  int                 ready_run   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel transaction: actual %06h", m_axis_tdata);
          errors++;
        end else begin
          want_pixel = pixel_q.pop_front();
          pixels_seen++;
          if (m_axis_tdata !== want_pixel) begin
            $error("pixel mismatch: expected %06h, actual %06h", want_pixel, m_axis_tdata);
            errors++;
          end
        end
      end
      if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (ready_run == 0) begin
          ready_state = !ready_state;
          ready_run   = ready_state ? $urandom_range(1, 16) : $urandom_range(1, 12);
        end
        ready_run--;
        m_axis_tready <= ready_state;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  int quiet = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d pixels outstanding",
                 QUIET_LIMIT, pixel_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Write one register and update the shadow once the transaction is taken
  task automatic write_reg(input cfg_reg_e idx, input logic [PIXEL_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SATURATION:  sat_reg   = data[SAT_W-1:0];
      CFG_BRIGHTNESS:  bri_reg   = data[SAT_W-1:0];
      CFG_SWAP_ORDER:  swap_reg  = data[0];
      CFG_BLACK_COLOR: black_reg = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [PIXEL_W-1:0] sat, input logic [PIXEL_W-1:0] bri,
                               input logic swap, input logic [PIXEL_W-1:0] black);
    write_reg(CFG_SATURATION, sat);
    write_reg(CFG_BRIGHTNESS, bri);
    write_reg(CFG_SWAP_ORDER, {16'($urandom_range(0, 'hFFFF)), 7'($urandom), swap});
    write_reg(CFG_BLACK_COLOR, black);
  endtask

  // Wait until every queued point has gone in and every pixel has come out
  task automatic drain_pipeline();
    do @(negedge clk_i); while (point_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic push_point(input logic diverged, input logic [CNT_W-1:0] count);
    point_t p;
    p.diverged = diverged;
    p.count    = count;
    point_q.push_back(p);
  endtask

  // Mostly escaped points; a third of them in the first two hue periods
  task automatic push_random_points(input int n);
    for (int i = 0; i < n; i++) begin
      push_point($urandom_range(0, 4) != 0,
                 ($urandom_range(0, 2) == 0) ? CNT_W'($urandom_range(0, 199))
                                             : CNT_W'($urandom));
    end
  endtask

  task automatic run_phase(input bit quiet_bus);
    @(negedge clk_i);
    calm = quiet_bus;
    settings_run++;
    push_random_points(RAND_POINTS);
    drain_pipeline();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting: bounded points, hue sector edges and count extremes
    push_point(1'b0, '0);
    push_point(1'b0, '1);
    push_point(1'b1, '0);
    push_point(1'b1, '1);
    push_point(1'b1, CNT_W'(65500));
    foreach (EDGE_COUNTS[i]) push_point(1'b1, CNT_W'(EDGE_COUNTS[i]));
    drain_pipeline();
    run_phase(1'b0);

    // Grey scale, swapped bytes, white for bounded points
    apply_setting(24'd0, 24'd256, 1'b1, 24'hFFFFFF);
    run_phase(1'b1);

    // Oversized fractions clamp to full scale; upper data bits are dropped
    apply_setting(24'hFFFFFF, 24'hFFE1FF, 1'b0, 24'(32'h00A5_5A3C));
    run_phase(1'b0);

    // Zero brightness gives black for every hue
    apply_setting(24'd256, 24'd0, 1'b1, 24'h000000);
    run_phase(1'b0);

    apply_setting(24'd1, 24'd1, 1'b0, 24'h123456);
    run_phase(1'b0);

    apply_setting(24'd255, 24'd255, 1'b1, 24'hEDCBA9);
    run_phase(1'b0);

    // Random settings, a few of them above full scale
    repeat (3) begin
      apply_setting(24'($urandom_range(0, 300)), 24'($urandom_range(0, 300)),
                    1'($urandom), 24'($urandom));
      run_phase(1'($urandom_range(0, 3) == 0));
    end

    $display("Covered %0d points (%0d bounded) over %0d register settings; %0d pixels checked.",
             points_sent, bounded_sent, settings_run, pixels_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
